/* rtl/core/acf_pkg.sv */
`default_nettype none
package acf_pkg;

  localparam int AtanLen = 24;
  localparam logic signed [35:0] Deg180 = 36'sd11796480;

  // register indexes
  localparam logic [2:0] REG_ALPHA    = 3'd0;
  localparam logic [2:0] REG_ANGLE_GN = 3'd1;
  localparam logic [2:0] REG_RATE_GN  = 3'd2;
  localparam logic [2:0] REG_MAG_LOW  = 3'd3;
  localparam logic [2:0] REG_MAG_HIGH = 3'd4;

  // arctangent table, Q16.16 degrees
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] r;
    begin
      unique case (i)
        5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;
        5'd2: r = 22'd919879;   5'd3: r = 22'd466945;
        5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
        5'd6: r = 22'd58666;    5'd7: r = 22'd29335;
        5'd8: r = 22'd14668;    5'd9: r = 22'd7334;
        5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
        5'd12: r = 22'd917;     5'd13: r = 22'd458;
        5'd14: r = 22'd229;     5'd15: r = 22'd115;
        5'd16: r = 22'd57;      5'd17: r = 22'd29;
        5'd18: r = 22'd14;      5'd19: r = 22'd7;
        5'd20: r = 22'd4;       5'd21: r = 22'd2;
        5'd22: r = 22'd1;       default: r = 22'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 32'h7fffffff;
      else if (v < -64'sd2147483648) return 32'h80000000;
      else return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/acf_serial_mul.sv */
`default_nettype none
// Shift-add multiplier: signed a times unsigned b, one bit of b per cycle.
module acf_serial_mul import acf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [35:0] a,
  input  wire logic [16:0]        b,
  output logic                    done,
  output logic signed [63:0]      prod
);
  logic [16:0] b_r, b_nxt;
  logic signed [63:0] a_r, a_nxt, acc_r, acc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    b_nxt = b_r; a_nxt = a_r; acc_nxt = acc_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done = 1'b0;
    if (start) begin
      a_nxt = 64'(a); b_nxt = b; acc_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = a_r <<< 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end
  assign prod = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
  end
endmodule
`default_nettype wire

/* rtl/core/acf_cordic.sv */
`default_nettype none
// Vectoring CORDIC atan2 in degrees, one micro-rotation per cycle.
module acf_cordic import acf_pkg::*; #(
  parameter int Steps = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [16:0] num,
  input  wire logic signed [16:0] den,
  output logic                    done,
  output logic signed [35:0]      angle
);
  localparam int NSteps = (Steps > AtanLen) ? AtanLen : Steps;

  logic signed [34:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [35:0] z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [34:0] xs, ys;
  logic signed [34:0] xi, yi;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  // inputs scaled by 2^14, sign carried into the top bits
  assign xi = {{4{den[16]}}, den, 14'd0};
  assign yi = {{4{num[16]}}, num, 14'd0};

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      i_nxt = '0; busy_nxt = 1'b1;
      if (den[16]) begin
        x_nxt = -xi; y_nxt = -yi;
        z_nxt = num[16] ? -Deg180 : Deg180;
      end else begin
        x_nxt = xi; y_nxt = yi; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (!y_r[34]) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + 36'(atan_lut(i_r));
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - 36'(atan_lut(i_r));
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(NSteps - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign angle = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; i_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; i_r <= i_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end
endmodule
`default_nettype wire

/* rtl/core/attitude_complementary_filter.sv */
`default_nettype none
// Complementary-filter attitude estimator.
// Input channel (in_valid/in_ready) takes one word of six raw IMU samples;
// output channel (out_valid/out_ready) gives one word of pitch, roll, yaw,
// yaw rate and the two blend flags per input word.
// Config writes (cfg_we/cfg_index/cfg_data) are registered; write only idle.
// A bit-serial multiplier does the four gyro products and the blend
// products; a one-step-per-cycle CORDIC does the atan2 evaluations.
// Each blended angle adds a CORDIC evaluation and two blend products. The
// input is ready in the cycle after the result is loaded.
// One sample is in work at a time; the result sits in an output register, and
// the next sample is taken while it waits. A stalled receiver holds the result
// and, once a second sample is finished, holds the input side too.
// Synchronous reset clears the angles to zero and registers to defaults.
module attitude_complementary_filter import acf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_accel_raw_x,
  input  wire logic signed [15:0] in_accel_raw_y,
  input  wire logic signed [15:0] in_accel_raw_z,
  input  wire logic signed [15:0] in_gyro_raw_x,
  input  wire logic signed [15:0] in_gyro_raw_y,
  input  wire logic signed [15:0] in_gyro_raw_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pitch_angle,
  output logic signed [31:0]      out_roll_angle,
  output logic signed [31:0]      out_yaw_angle,
  output logic signed [31:0]      out_yaw_rate,
  output logic                    out_pitch_corrected,
  output logic                    out_roll_corrected,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MP = 4'd1, S_MR = 4'd2, S_MY = 4'd3,
    S_MRATE = 4'd4, S_CHK = 4'd5, S_CP = 4'd6, S_BP1 = 4'd7, S_BP2 = 4'd8,
    S_CR = 4'd9, S_BR1 = 4'd10, S_BR2 = 4'd11, S_DONE = 4'd12;

  logic [16:0] alpha_r, mag_low_r, mag_high_r;
  logic [15:0] angle_gain_r, rate_gain_r;
  logic signed [31:0] pitch_r, roll_r, yaw_r, rate_r;
  logic signed [16:0] ax_r, ay_r, az_r, gp_r, gr_r, gy_r;
  logic [3:0] st_r, st_nxt;
  logic go_r, go_nxt;
  logic pc_r, rc_r;
  logic signed [63:0] acc_r;
  logic signed [35:0] atan_r;
  logic ov_r;
  logic signed [31:0] o_p_r, o_r_r, o_y_r, o_rate_r;
  logic o_pc_r, o_rc_r;

  // multiplier operands
  logic signed [35:0] m_a;
  logic [16:0] m_b;
  logic m_done;
  logic signed [63:0] m_prod;
  logic c_start, c_done;
  logic signed [16:0] c_num;
  logic signed [35:0] c_ang;

  logic [16:0] alpha_c, abs_ax, abs_ay, abs_az;
  logic [17:0] mag;
  logic signed [63:0] bsum;
  logic signed [31:0] bres;

  assign alpha_c = (alpha_r > 17'd65536) ? 17'd65536 : alpha_r;
  assign abs_ax = ax_r[16] ? -ax_r : ax_r;
  assign abs_ay = ay_r[16] ? -ay_r : ay_r;
  assign abs_az = az_r[16] ? -az_r : az_r;
  assign mag = 18'(abs_ax) + 18'(abs_ay) + 18'(abs_az);
  assign bsum = acc_r + m_prod + 64'sd32768;
  assign bres = sat32(bsum >>> 16);

  always_comb begin
    m_a = 36'(gp_r); m_b = {1'b0, angle_gain_r};
    unique case (st_r)
      S_MR: m_a = 36'(gr_r);
      S_MY: m_a = 36'(gy_r);
      S_MRATE: begin m_a = 36'(gy_r); m_b = {1'b0, rate_gain_r}; end
      S_BP1: begin m_a = 36'(pitch_r); m_b = alpha_c; end
      S_BR1: begin m_a = 36'(roll_r); m_b = alpha_c; end
      S_BP2, S_BR2: begin m_a = atan_r; m_b = 17'd65536 - alpha_c; end
      default: ;
    endcase
  end

  acf_serial_mul u_mul (.clk, .rst_n, .start(go_r), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_prod));

  // numerator picked by the state the CORDIC is started for
  assign c_num = (st_nxt == S_CP) ? ax_r : ay_r;
  acf_cordic #(.Steps(CORDIC_STEPS)) u_cordic (.clk, .rst_n, .start(c_start),
    .num(c_num), .den(az_r), .done(c_done), .angle(c_ang));

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_pitch_angle = o_p_r;
  assign out_roll_angle = o_r_r;
  assign out_yaw_angle = o_y_r;
  assign out_yaw_rate = o_rate_r;
  assign out_pitch_corrected = o_pc_r;
  assign out_roll_corrected = o_rc_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; go_nxt = 1'b0; c_start = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) begin st_nxt = S_MP; go_nxt = 1'b1; end
      S_MP: if (m_done) begin st_nxt = S_MR; go_nxt = 1'b1; end
      S_MR: if (m_done) begin st_nxt = S_MY; go_nxt = 1'b1; end
      S_MY: if (m_done) begin st_nxt = S_MRATE; go_nxt = 1'b1; end
      S_MRATE: if (m_done) st_nxt = S_CHK;
      S_CHK: begin
        if (mag > 18'(mag_low_r) && mag < 18'(mag_high_r) && abs_ax < abs_az) begin
          st_nxt = S_CP; c_start = 1'b1;
        end else if (mag > 18'(mag_low_r) && mag < 18'(mag_high_r)
                     && abs_ay < abs_az) begin
          st_nxt = S_CR; c_start = 1'b1;
        end else st_nxt = S_DONE;
      end
      S_CP: if (c_done) begin st_nxt = S_BP1; go_nxt = 1'b1; end
      S_BP1: if (m_done) begin st_nxt = S_BP2; go_nxt = 1'b1; end
      S_BP2: if (m_done) begin
        if (abs_ay < abs_az) begin st_nxt = S_CR; c_start = 1'b1; end
        else st_nxt = S_DONE;
      end
      S_CR: if (c_done) begin st_nxt = S_BR1; go_nxt = 1'b1; end
      S_BR1: if (m_done) begin st_nxt = S_BR2; go_nxt = 1'b1; end
      S_BR2: if (m_done) st_nxt = S_DONE;
      S_DONE: if (!ov_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; go_r <= 1'b0; ov_r <= 1'b0;
      alpha_r <= 17'd65438; angle_gain_r <= 16'd8; rate_gain_r <= 16'd4000;
      mag_low_r <= 17'd1024; mag_high_r <= 17'd4096;
      pitch_r <= '0; roll_r <= '0; yaw_r <= '0;
    end else begin
      st_r <= st_nxt; go_r <= go_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ALPHA: alpha_r <= cfg_data;
          REG_ANGLE_GN: angle_gain_r <= cfg_data[15:0];
          REG_RATE_GN: rate_gain_r <= cfg_data[15:0];
          REG_MAG_LOW: mag_low_r <= cfg_data;
          REG_MAG_HIGH: mag_high_r <= cfg_data;
          default: ;
        endcase
      end
      // angle updates
      if (m_done) begin
        unique case (st_r)
          S_MP: pitch_r <= sat32(64'(pitch_r) + m_prod);
          S_MR: roll_r <= sat32(64'(roll_r) + m_prod);
          S_MY: yaw_r <= sat32(64'(yaw_r) + m_prod);
          S_BP2: pitch_r <= bres;
          S_BR2: roll_r <= bres;
          default: ;
        endcase
      end
      // result valid: loaded from S_DONE, cleared when taken
      if (st_r == S_DONE && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
    end
    // payload
    if (st_r == S_IDLE && in_valid) begin
      ax_r <= -17'(in_accel_raw_x); ay_r <= -17'(in_accel_raw_y);
      az_r <= 17'(in_accel_raw_z); gr_r <= -17'(in_gyro_raw_x);
      gp_r <= 17'(in_gyro_raw_y); gy_r <= -17'(in_gyro_raw_z);
      pc_r <= 1'b0; rc_r <= 1'b0;
    end
    if (m_done && st_r == S_MRATE) rate_r <= sat32(m_prod);
    if (m_done && (st_r == S_BP1 || st_r == S_BR1)) acc_r <= m_prod;
    if (c_done) atan_r <= c_ang;
    if (st_r == S_CP) pc_r <= 1'b1;
    if (st_r == S_CR) rc_r <= 1'b1;
    if (st_r == S_DONE && (!ov_r || out_ready)) begin
      o_p_r <= pitch_r; o_r_r <= roll_r; o_y_r <= yaw_r; o_rate_r <= rate_r;
      o_pc_r <= pc_r; o_rc_r <= rc_r;
    end
  end
endmodule
`default_nettype wire
